// ===== src/mtg_pkg.sv =====
// Package for the MT19937 generator: widths, recurrence constants and the
// combinational helpers (LCG step, twist, tempering). No dependencies.
`default_nettype none

package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int CNT_W        = $clog2(STATE_WORDS);

	typedef logic [31:0] word_t;

	localparam word_t MAT_A        = 32'h9908b0df;
	localparam word_t HI_BIT       = 32'h80000000;
	localparam word_t LO_BITS      = 32'h7fffffff;
	localparam word_t TEMPER_B     = 32'h9d2c5680;
	localparam word_t TEMPER_C     = 32'hefc60000;
	localparam word_t LCG_MUL      = 32'd69069;
	localparam word_t SEED_DEFAULT = 32'd4357;

	typedef struct packed {
		logic  push;
		word_t word;
		logic  done;
	} seed_ctrl_t;

	function automatic word_t lcg_next(word_t x);
		word_t p;
		p = x * LCG_MUL;
		return p + 32'd1;
	endfunction

	function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
		word_t y;
		y = (cur & HI_BIT) | (nxt & LO_BITS);
		return far ^ (y >> 1) ^ (y[0] ? MAT_A : 32'd0);
	endfunction

	function automatic word_t temper(word_t v);
		word_t y;
		y = v;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

// ===== src/mtg_ifs.sv =====
// Valid/ready channel interfaces for requests, result words and seed writes.
// Depends on mtg_pkg.
`default_nettype none

interface mtg_req_if;
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface mtg_word_if import mtg_pkg::*; ;
	logic  valid;
	logic  ready;
	word_t random_word;
	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

interface mtg_cfg_if import mtg_pkg::*; ;
	logic  valid;
	logic  ready;
	word_t seed_value;
	modport source (output valid, output seed_value, input ready);
	modport sink   (input valid, input seed_value, output ready);
endinterface

`default_nettype wire

// ===== src/mtg_cell.sv =====
// One state cell of the circular shift line: holds a 32-bit word and takes
// its d input, the next cell's word or the new tail word, on every shift. Depends on mtg_pkg.
`default_nettype none

module mtg_cell import mtg_pkg::*; (
	input  wire   clk,
	input  wire   shift,
	input  word_t d,
	output word_t q
);

	word_t word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

`default_nettype wire

// ===== src/mtg_seeder.sv =====
// Seeding sequencer: runs the 69069 LCG, one step a cycle, and pushes one
// state word per two LCG steps into the tail of the cell line. Depends on mtg_pkg.
`default_nettype none

module mtg_seeder import mtg_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  word_t      seed,
	output seed_ctrl_t ctrl
);

	typedef enum logic {SD_IDLE, SD_RUN} sd_state_t;

	localparam logic [CNT_W-1:0] LAST = CNT_W'(STATE_WORDS - 1);

	sd_state_t        state_q;
	logic             phase_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            lcg_q;
	logic [15:0]      hi_q;

	assign ctrl.push = (state_q == SD_RUN) && phase_q;
	assign ctrl.word = {hi_q, lcg_q[31:16]};
	assign ctrl.done = ctrl.push && (cnt_q == LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SD_IDLE;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				SD_IDLE: begin
					if (start) begin
						state_q <= SD_RUN;
						phase_q <= 1'b0;
						cnt_q   <= '0;
						lcg_q   <= seed;
					end
				end
				SD_RUN: begin
					lcg_q   <= lcg_next(lcg_q);
					phase_q <= !phase_q;
					if (!phase_q) begin
						hi_q <= lcg_q[31:16];
					end else if (cnt_q == LAST) begin
						state_q <= SD_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= SD_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/mersenne_twister_generator_top.sv =====
// MT19937 generator top level: seed register, request control, lazy twist,
// tempering and output register. Depends on mtg_pkg, mtg_ifs, mtg_cell, mtg_seeder.
//
// Each request beat returns one tempered 32-bit word. Once seeded, a request is
// taken every cycle while the output register is free or being read, and its
// word appears on the next cycle: the 624 state words sit in a circular line of
// cells, the head word and its neighbours at offsets 1 and 397 form the twisted
// word, and the line shifts by one per word. The first request after reset, and
// any request with restart set, first reseeds: the LCG runs one multiply a
// cycle, two steps per state word, and once the line is seeded the word for that
// request is produced. A seed write takes effect at the next reseed.
`default_nettype none

module mersenne_twister_generator_top import mtg_pkg::*; (
	input wire          clk,
	input wire          arst_n,
	mtg_req_if.sink     req,
	mtg_word_if.source  rsp,
	mtg_cfg_if.sink     cfg
);

	typedef enum logic [1:0] {ST_RUN, ST_SEED, ST_PROD} st_t;

	st_t        state_q;
	logic       seeded_q;
	word_t      seed_q;
	logic       out_valid_q;
	word_t      out_word_q;

	seed_ctrl_t sd;
	logic       slot_free;
	logic       req_beat;
	logic       reseed;
	logic       produce;
	logic       shift;
	word_t      new_word;
	word_t      tail;
	word_t      chain_w [STATE_WORDS];

	assign slot_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_RUN) && slot_free;
	assign req_beat  = req.valid && req.ready;
	assign reseed    = req_beat && (req.restart || !seeded_q);
	assign produce   = (req_beat && !reseed) || ((state_q == ST_PROD) && slot_free);
	assign cfg.ready = 1'b1;

	assign new_word = twist_word(chain_w[0], chain_w[1], chain_w[TWIST_OFFSET]);
	assign tail     = sd.push ? sd.word : new_word;
	assign shift    = sd.push || produce;

	mtg_seeder u_seeder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (reseed),
		.seed   (seed_q),
		.ctrl   (sd)
	);

	for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
		if (i == STATE_WORDS - 1) begin : g_tail
			mtg_cell u_cell (.clk(clk), .shift(shift), .d(tail), .q(chain_w[i]));
		end else begin : g_body
			mtg_cell u_cell (.clk(clk), .shift(shift), .d(chain_w[i+1]), .q(chain_w[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			seeded_q    <= 1'b0;
			seed_q      <= SEED_DEFAULT;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				seed_q <= cfg.seed_value;
			end
			case (state_q)
				ST_RUN:  if (reseed) state_q <= ST_SEED;
				ST_SEED: begin
					if (sd.done) begin
						state_q  <= ST_PROD;
						seeded_q <= 1'b1;
					end
				end
				ST_PROD: if (slot_free) state_q <= ST_RUN;
				default: state_q <= ST_RUN;
			endcase
			if (produce) begin
				out_valid_q <= 1'b1;
				out_word_q  <= temper(new_word);
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.random_word = out_word_q;

	a_no_req_while_seeding: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED) |-> !req.ready)
		else $error("request taken while seeding");

	a_word_only_when_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> seeded_q)
		else $error("word offered from unseeded state");

	a_restart_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		(req_beat && req.restart) |=> (state_q == ST_SEED))
		else $error("restart did not start seeding");

	a_done_in_seed: assert property (@(posedge clk) disable iff (!arst_n)
		sd.push |-> (state_q == ST_SEED))
		else $error("seed push outside seeding");

	a_no_shift_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(sd.push && produce))
		else $error("seed push and word production in the same cycle");

endmodule

`default_nettype wire

// ===== tb/mersenne_twister_generator_top_tb.sv =====
// Testbench for the MT19937 generator top level: seeded requests checked beat by beat
// against an in-bench MT19937 predictor, with random idling and stalls on both sides.
// Depends on mtg_pkg, mtg_ifs and the generator RTL.
`timescale 1ns / 1ps

module mersenne_twister_generator_top_tb;
	import mtg_pkg::*;

	localparam word_t HALF_HI    = 32'hffff0000;
	localparam int    GAP_MAX    = 13;
	localparam int    HOLD_AT    = 60;
	localparam int    HOLD_LEN   = 300;
	localparam int    STALL_LIMIT = 8000;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	mtg_req_if  req_ch ();
	mtg_word_if word_ch ();
	mtg_cfg_if  cfg_ch ();

	mersenne_twister_generator_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (word_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	word_t       tw_words [STATE_WORDS];
	int unsigned tw_pos = STATE_WORDS + 1;
	word_t       seed_reg = SEED_DEFAULT;

	bit    pending_restarts [$];
	word_t word_due [$];
	int    mismatches = 0;
	int    words_seen = 0;
	bit    req_burst = 1'b0;
	bit    rsp_burst = 1'b0;

	function automatic word_t next_tempered_word(bit restart);
		word_t s, w, y;
		int    nxt, far;
		if (restart || tw_pos > STATE_WORDS) begin
			s = seed_reg;
			for (int i = 0; i < STATE_WORDS; i++) begin
				w = s & HALF_HI;
				s = s * LCG_MUL + 32'd1;
				w = w | ((s & HALF_HI) >> 16);
				s = s * LCG_MUL + 32'd1;
				tw_words[i] = w;
			end
			tw_pos = STATE_WORDS;
		end
		if (tw_pos >= STATE_WORDS) begin
			for (int k = 0; k < STATE_WORDS; k++) begin
				nxt = (k + 1) % STATE_WORDS;
				far = (k + TWIST_OFFSET) % STATE_WORDS;
				y = (tw_words[k] & HI_BIT) | (tw_words[nxt] & LO_BITS);
				tw_words[k] = tw_words[far] ^ (y >> 1) ^ (y[0] ? MAT_A : 32'd0);
			end
			tw_pos = 0;
		end
		y = tw_words[tw_pos];
		tw_pos++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	// request driver
	int req_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		bit nv, nr;
		if (!arst_n) begin
			req_ch.valid   <= 1'b0;
			req_ch.restart <= 1'b0;
			req_gap = 0;
		end else begin
			nv = req_ch.valid;
			nr = req_ch.restart;
			if (req_ch.valid && req_ch.ready) begin
				word_due.push_back(next_tempered_word(req_ch.restart));
				nv = 1'b0;
				if ($urandom_range(0, 39) == 0)
					req_burst = ~req_burst;
				req_gap = draw_gap(req_burst);
			end
			if (!nv) begin
				if (req_gap > 0)
					req_gap--;
				else if (pending_restarts.size() != 0) begin
					nv = 1'b1;
					nr = pending_restarts.pop_front();
				end
			end
			req_ch.valid   <= nv;
			req_ch.restart <= nr;
		end
	end

	// result monitor
	int rsp_gap = 0;
	int hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			word_ch.ready <= 1'b0;
			rsp_gap = 0;
			hold_left = 0;
		end else begin
			if (word_ch.valid && word_ch.ready) begin
				if (word_due.size() == 0) begin
					$error("random_word: expected none, got %h", word_ch.random_word);
					mismatches++;
				end else begin
					want = word_due.pop_front();
					if (word_ch.random_word !== want) begin
						$error("random_word: expected %h, got %h", want, word_ch.random_word);
						mismatches++;
					end
				end
				words_seen++;
				if (words_seen == HOLD_AT)
					hold_left = HOLD_LEN;
				if ($urandom_range(0, 39) == 0)
					rsp_burst = ~rsp_burst;
				rsp_gap = draw_gap(rsp_burst);
			end
			if (hold_left > 0) begin
				hold_left--;
				word_ch.ready <= 1'b0;
			end else if (rsp_gap > 0) begin
				rsp_gap--;
				word_ch.ready <= 1'b0;
			end else begin
				word_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog: cycles without any beat
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (word_ch.valid && word_ch.ready) ||
			    (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// checked mid-cycle so the driver's updates from the last edge are visible
	task automatic settle();
		do
			@(negedge clk);
		while (pending_restarts.size() != 0 || req_ch.valid || word_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(word_t v);
		cfg_ch.valid      <= 1'b1;
		cfg_ch.seed_value <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		seed_reg = v;
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		word_t s;
		int    n;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.restart    = 1'b0;
		word_ch.ready     = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.seed_value = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default seed: first request seeds without restart, then an explicit restart
		pending_restarts = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
		settle();

		// new seed only counts from the next restart
		write_seed(32'h0);
		pending_restarts = '{1'b0, 1'b1, 1'b0, 1'b0};
		settle();

		write_seed(32'hffffffff);
		pending_restarts = '{1'b1, 1'b0, 1'b1, 1'b0};
		settle();

		// long run without restarts across the twist boundary
		repeat (STATE_WORDS + 6)
			pending_restarts.push_back(1'b0);
		settle();

		// short phases with seed changes and scattered restarts
		for (int p = 0; p < 4; p++) begin
			case ($urandom_range(0, 3))
				0: s = 32'h0;
				1: s = 32'hffffffff;
				2: s = SEED_DEFAULT;
				default: s = $urandom();
			endcase
			write_seed(s);
			n = $urandom_range(4, 10);
			pending_restarts.push_back($urandom_range(0, 1));
			repeat (n)
				pending_restarts.push_back($urandom_range(0, 7) == 0);
			settle();
		end

		settle();
		repeat (20) @(posedge clk);
		foreach (word_due[i]) begin
			$error("random_word: expected %h, got none", word_due[i]);
			mismatches++;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
